[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL, used by rank_order_filter_rgb.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, a, b)
`define ASSERT_NEXT(lbl, a, b)
`endif
`endif

[hw/rtl/rof_pkg.sv]
// Types and constants of the rank-order filter.
package rof_pkg;
  localparam int MAX_WINDOW_DEF = 7;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_SIDE       = 1024;
  localparam int PIX_W          = 8;
  localparam int PX_W           = 3 * PIX_W;
  localparam int POS_W          = 10;
  localparam int DIM_W          = 11;
  localparam int SIZE_W         = 3;
  localparam int RANK_W         = 6;
  localparam int CFG_IDX_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE = 2'd0,
    REG_RANK_INDEX  = 2'd1,
    REG_IMAGE_WIDTH = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     value;
  } cfg_req_t;

  typedef struct packed {
    logic [PX_W-1:0]  px;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
    logic             emit;
    logic             pass;
  } meta_t;
endpackage

[hw/rtl/rof_chan_if.sv]
// Valid/ready channel carrying one request payload.
interface rof_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rank_order_filter_rgb.sv]
// RGB rank-order filter over a square window of odd side, pixels in raster order.
// Pipeline: line store read and s1 register, window, rank and output registers.
// Throughput: one pixel per cycle unless stalled, set by the 1R1W line store per line.
// Reset: synchronous active-low rst_n clears positions, valid bits, window and
// registers (size 3, rank 4, 1024 x 1024); line store contents stay unknown until written.
`include "assert_macros.svh"
module rank_order_filter_rgb import rof_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  rof_chan_if.sink   in_ch,
  rof_chan_if.source out_ch,
  rof_chan_if.sink   cfg_ch
);
  localparam int NL  = MAX_WINDOW - 1;
  localparam int LW  = $clog2(NL);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int NE  = MAX_WINDOW * MAX_WINDOW;
  localparam int WHI = (MAX_WIDTH < MAX_SIDE) ? MAX_WIDTH : MAX_SIDE;

  function automatic logic [LW-1:0] lane_inc(input logic [LW-1:0] l);
    return (l == LW'(NL - 1)) ? '0 : l + 1'b1;
  endfunction

  function automatic logic [LW-1:0] lane_back(input logic [LW-1:0] cur, input int k);
    logic [LW:0] t;
    t = {1'b0, cur} + (LW+1)'(NL - k);
    if (t >= (LW+1)'(NL)) t = t - (LW+1)'(NL);
    return t[LW-1:0];
  endfunction

  logic [SIZE_W-1:0] ws_r;
  logic [RANK_W-1:0] rk_r;
  logic [DIM_W-1:0]  iw_r, ih_r;
  logic [DIM_W-1:0]  w, h;
  logic [POS_W-1:0]  row_r, col_r;
  logic [LW-1:0]     lane_r;
  logic [DIM_W-1:0]  row0, col0, row1, col1;
  logic [LW-1:0]     lane0, lane1;
  logic              ok, acc;
  logic [SIZE_W-1:0] span, half;
  pix_in_t           pin;
  meta_t             m0, s1_r, s2_r, s3_r;
  logic              v1_r, v2_r, v3_r, out_v_r;
  logic              r1, r2, r3, r4;
  logic [LW-1:0]     s1_lane_r;
  logic [AW-1:0]     addr;
  logic [PX_W-1:0]   rd_r [NL];
  logic [PX_W-1:0]   win_r [MAX_WINDOW][MAX_WINDOW];
  logic [NE-1:0]     act;
  logic [PIX_W-1:0]  vr [NE];
  logic [PIX_W-1:0]  vg [NE];
  logic [PIX_W-1:0]  vb [NE];
  logic [PIX_W-1:0]  sr, sg, sb;
  pix_out_t          out_r;
  cfg_req_t          creq;

  assign pin  = in_ch.data;
  assign creq = cfg_ch.data;

  always_comb begin
    w = (iw_r == '0) ? DIM_W'(1) : (iw_r > DIM_W'(WHI)) ? DIM_W'(WHI) : iw_r;
    h = (ih_r == '0) ? DIM_W'(1) : (ih_r > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : ih_r;
    ok = ws_r[0] && (int'(ws_r) <= MAX_WINDOW)
         && ({1'b0, rk_r} < (7'(ws_r) * 7'(ws_r)));
    span = ws_r - 1'b1;
    half = ws_r >> 1;
  end

  always_comb begin
    if (pin.frame_start) begin
      row0  = '0;
      col0  = '0;
      lane0 = '0;
    end else begin
      row0  = {1'b0, row_r};
      col0  = {1'b0, col_r};
      lane0 = lane_r;
      if (col0 >= w) begin
        col0  = '0;
        row0  = row0 + 1'b1;
        lane0 = lane_inc(lane0);
      end
      if (row0 >= h) begin
        row0  = '0;
        lane0 = '0;
      end
    end
    col1  = col0 + 1'b1;
    row1  = row0;
    lane1 = lane0;
    if (col1 >= w) begin
      col1  = '0;
      row1  = row1 + 1'b1;
      lane1 = lane_inc(lane1);
      if (row1 >= h) begin
        row1  = '0;
        lane1 = '0;
      end
    end
    m0.px   = {pin.red, pin.green, pin.blue};
    m0.row  = ok ? POS_W'(row0 - DIM_W'(half)) : row0[POS_W-1:0];
    m0.col  = ok ? POS_W'(col0 - DIM_W'(half)) : col0[POS_W-1:0];
    m0.last = (row0 == h - 1'b1) && (col0 == w - 1'b1);
    m0.pass = !ok;
    m0.emit = !ok || ((row0 >= DIM_W'(span)) && (col0 >= DIM_W'(span)));
    addr    = AW'(col0);
  end

  assign r4 = !out_v_r || out_ch.ready;
  assign r3 = !v3_r || r4;
  assign r2 = !v2_r || r3;
  assign r1 = !v1_r || r2;
  assign in_ch.ready = r1;
  assign acc = in_ch.valid && r1;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= SIZE_W'(3);
      rk_r <= RANK_W'(4);
      iw_r <= DIM_W'(1024);
      ih_r <= DIM_W'(1024);
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(creq.index))
        REG_WINDOW_SIZE:  ws_r <= creq.value[SIZE_W-1:0];
        REG_RANK_INDEX:   rk_r <= creq.value[RANK_W-1:0];
        REG_IMAGE_WIDTH:  iw_r <= creq.value;
        REG_IMAGE_HEIGHT: ih_r <= creq.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      lane_r <= '0;
    end else if (acc) begin
      row_r  <= row1[POS_W-1:0];
      col_r  <= col1[POS_W-1:0];
      lane_r <= lane1;
    end
  end

  for (genvar m = 0; m < NL; m++) begin : g_line
    logic [PX_W-1:0] lmem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (acc) begin
        rd_r[m] <= lmem[addr];
        if (lane0 == LW'(m)) begin
          lmem[addr] <= m0.px;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (r1) v1_r <= in_ch.valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) out_v_r <= v3_r && s3_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r      <= m0;
      s1_lane_r <= lane0;
    end
    if (r2) s2_r <= s1_r;
    if (r3) s3_r <= s2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_WINDOW; r++) begin
        for (int c = 0; c < MAX_WINDOW; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (r2 && v1_r) begin
      for (int r = 0; r < MAX_WINDOW; r++) begin
        for (int c = 0; c < MAX_WINDOW - 1; c++) begin
          win_r[r][c] <= win_r[r][c+1];
        end
      end
      win_r[MAX_WINDOW-1][MAX_WINDOW-1] <= s1_r.px;
      for (int k = 1; k <= NL; k++) begin
        win_r[MAX_WINDOW-1-k][MAX_WINDOW-1] <= rd_r[lane_back(s1_lane_r, k)];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < MAX_WINDOW; r++) begin
      for (int c = 0; c < MAX_WINDOW; c++) begin
        act[r*MAX_WINDOW+c] = (r >= MAX_WINDOW - int'(ws_r)) && (c >= MAX_WINDOW - int'(ws_r));
        vr[r*MAX_WINDOW+c]  = win_r[r][c][3*PIX_W-1:2*PIX_W];
        vg[r*MAX_WINDOW+c]  = win_r[r][c][2*PIX_W-1:PIX_W];
        vb[r*MAX_WINDOW+c]  = win_r[r][c][PIX_W-1:0];
      end
    end
  end

  rof_rank #(.N(NE)) u_rank_r (
    .clk(clk), .rst_n(rst_n), .ld(r3), .vals(vr), .act(act), .rank(rk_r), .sel(sr));
  rof_rank #(.N(NE)) u_rank_g (
    .clk(clk), .rst_n(rst_n), .ld(r3), .vals(vg), .act(act), .rank(rk_r), .sel(sg));
  rof_rank #(.N(NE)) u_rank_b (
    .clk(clk), .rst_n(rst_n), .ld(r3), .vals(vb), .act(act), .rank(rk_r), .sel(sb));

  always_ff @(posedge clk) begin
    if (r4) begin
      out_r.out_red   <= s3_r.pass ? s3_r.px[3*PIX_W-1:2*PIX_W] : sr;
      out_r.out_green <= s3_r.pass ? s3_r.px[2*PIX_W-1:PIX_W] : sg;
      out_r.out_blue  <= s3_r.pass ? s3_r.px[PIX_W-1:0] : sb;
      out_r.out_row   <= s3_r.row;
      out_r.out_col   <= s3_r.col;
      out_r.frame_end <= s3_r.last;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  `ASSERT_IMPL(a_lane_range, 1'b1, {1'b0, lane_r} < (LW+1)'(NL))
  `ASSERT_IMPL(a_stall_full, !in_ch.ready, v1_r && v2_r && v3_r && out_v_r)
  `ASSERT_NEXT(a_rank_hold, v3_r && !r3, v3_r)
endmodule

[hw/rtl/rof_rank.sv]
// Rank selection of one color channel over the window, one register stage.
module rof_rank import rof_pkg::*; #(
  parameter int N = MAX_WINDOW_DEF * MAX_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld,
  input  logic [PIX_W-1:0]  vals [N],
  input  logic [N-1:0]      act,
  input  logic [RANK_W-1:0] rank,
  output logic [PIX_W-1:0]  sel
);
  logic [N-1:0]     lt [N];
  logic [N-1:0]     hit;
  logic [N-1:0]     hit_r;
  logic [PIX_W-1:0] vals_r [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        lt[i][j] = act[j] && ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)));
      end
      hit[i] = act[i] && (8'($countones(lt[i])) == 8'(rank));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= '0;
    end else if (ld) begin
      hit_r <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      vals_r <= vals;
    end
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < N; i++) begin
      sel = sel | (hit_r[i] ? vals_r[i] : '0);
    end
  end
endmodule
